// ===== src/tmwf_pkg.sv =====
// shared types, constants and trim-bound helpers for the trimmed mean window filter
package tmwf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 5;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam int WIN_MIN     = 3;
    localparam int WIN_RESET   = 3;
    localparam int TRIM_LO_PCT = 15;
    localparam int TRIM_HI_PCT = 85;
    localparam int PCT_SCALE   = 100;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        sample_t  data;
    } cell_ctrl_t;

    typedef struct packed {
        logic    vld;
        logic    gt;
        sample_t value;
    } cell_link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    // first kept rank, evaluated on constants only
    function automatic int trim_lo_of(input int n);
        int lo;
        lo = (n * TRIM_LO_PCT) / PCT_SCALE;
        if (lo < 1)
        begin
            lo = 1;
        end
        return lo;
    endfunction

    // first dropped rank at the top end
    function automatic int trim_hi_of(input int n);
        int hi;
        hi = (n * TRIM_HI_PCT) / PCT_SCALE + 1;
        if (hi > n - 1)
        begin
            hi = n - 1;
        end
        return hi;
    endfunction

endpackage

// ===== src/trimmed_mean_window_filter_top.sv =====
// top level of the trimmed mean window filter: ring store, sorting chain, sum and divide
//
//  channel   | valid           | stall           | payload
//  ----------+-----------------+-----------------+--------------------------------
//  input     | sample_valid    | sample_stall    | sample (signed 16)
//  output    | smoothed_valid  | smoothed_stall  | smoothed (signed 16)
//  config    | psel & penable  | pready (=1)     | paddr, pwrite, pwdata, prdata
//
// a sample passes through the one-value-per-cycle insert into the cell chain, the
// shift-out of the sorted chain and the one-bit-per-cycle divider before its result
// is registered; the accumulator is SUM_W bits wide (21 for a 16 entry window)
// reset clears the ring store, write pointer and chain, and sets the window to 3
// sample_stall stays high from the transfer until the result has moved to the output
// register; a stalled output holds its result while the next sample is accepted
module trimmed_mean_window_filter_top
    import tmwf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample channel
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    // result channel
    output logic                       smoothed_valid,
    input  logic                       smoothed_stall,
    output logic signed [SAMPLE_W-1:0] smoothed,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic        [APB_AW-1:0]   paddr,
    input  logic        [APB_DW-1:0]   pwdata,
    output logic        [APB_DW-1:0]   prdata,
    output logic                       pready
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_W + WIN_W;

    // window size register and its write decode
    logic [WIN_W-1:0] window_reg;
    logic [WIN_W-1:0] window_next;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_odd;

    // ring store and pointer
    sample_t          store_reg [MAX_WINDOW];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [WIN_W-1:0] wp_inc;
    logic             store_we;
    sample_t          store_rd;

    // sequencer
    state_t           state_reg;
    state_t           state_next;
    logic [WIN_W-1:0] rd_reg;
    logic [WIN_W-1:0] rd_next;
    logic [WIN_W-1:0] rank_reg;
    logic [WIN_W-1:0] rank_next;
    logic signed [SUM_W-1:0] acc_reg;
    logic signed [SUM_W-1:0] acc_next;

    // trim bounds for every window size
    logic [WIN_W-1:0] lo_tab [MAX_WINDOW+1];
    logic [WIN_W-1:0] hi_tab [MAX_WINDOW+1];
    logic [WIN_W-1:0] trim_lo;
    logic [WIN_W-1:0] trim_hi;
    logic             in_range;
    logic             last_rank;

    // cell chain
    cell_ctrl_t       cell_ctrl;
    cell_link_t       links [MAX_WINDOW];

    // divider and output register
    logic             div_start;
    logic             div_done;
    sample_t          div_quotient;
    logic             out_load;
    logic             smoothed_valid_reg;
    sample_t          smoothed_reg;

    // ---------------------------------------------------------------- config port
    assign cfg_we  = psel && penable && pwrite && (paddr[APB_AW-1] == REG_WINDOW);
    // even values round up; a 5-bit even value plus one still fits
    assign cfg_odd = pwdata[CFG_W-1:0] | CFG_W'(1);

    always_comb
    begin
        if (int'(cfg_odd) > MAX_WINDOW)
        begin
            window_next = WIN_W'(MAX_WINDOW);
        end
        else if (int'(cfg_odd) < WIN_MIN)
        begin
            window_next = WIN_W'(WIN_MIN);
        end
        else
        begin
            window_next = WIN_W'(cfg_odd);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_WINDOW) ? APB_DW'(window_reg) : '0;

    // ---------------------------------------------------------------- trim tables
    for (genvar g = 0; g <= MAX_WINDOW; g++)
    begin : g_bounds
        assign lo_tab[g] = WIN_W'(trim_lo_of(g));
        assign hi_tab[g] = WIN_W'(trim_hi_of(g));
    end

    assign trim_lo   = lo_tab[window_reg];
    assign trim_hi   = hi_tab[window_reg];
    assign in_range  = (rank_reg >= trim_lo) && (rank_reg < trim_hi);
    assign last_rank = (rank_reg == trim_hi - 1'b1);

    // ---------------------------------------------------------------- ring store
    // pointer advances first, then the sample lands in the new slot
    assign wp_inc   = WIN_W'(wp_reg) + 1'b1;
    assign store_rd = store_reg[rd_reg[PTR_W-1:0]];

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rd_next        = rd_reg;
        rank_next      = rank_reg;
        acc_next       = acc_reg;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.data = store_rd;
        store_we       = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    wp_next      = (wp_inc >= window_reg) ? '0 : wp_inc[PTR_W-1:0];
                    store_we     = 1'b1;
                    cell_ctrl.op = CELL_CLEAR;
                    rd_next      = '0;
                    acc_next     = '0;
                    state_next   = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // one window entry per cycle into the chain
                cell_ctrl.op = CELL_INSERT;
                rd_next      = rd_reg + 1'b1;
                if (rd_reg == window_reg - 1'b1)
                begin
                    rank_next  = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // the smallest remaining value sits in cell 0
                cell_ctrl.op = CELL_SHIFT;
                if (in_range)
                begin
                    acc_next = acc_reg + SUM_W'(links[0].value);
                end
                rank_next = rank_reg + 1'b1;
                if (last_rank)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output register free, or emptied at this edge
                if (!smoothed_valid_reg || !smoothed_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            window_reg <= WIN_W'(WIN_RESET);
            wp_reg     <= '0;
            rd_reg     <= '0;
            rank_reg   <= '0;
            acc_reg    <= '0;
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            rd_reg    <= rd_next;
            rank_reg  <= rank_next;
            acc_reg   <= acc_next;
            if (cfg_we)
            begin
                // a new window size starts from an empty store
                window_reg <= window_next;
                wp_reg     <= '0;
                for (int i = 0; i < MAX_WINDOW; i++)
                begin
                    store_reg[i] <= '0;
                end
            end
            else
            begin
                wp_reg <= wp_next;
                if (store_we)
                begin
                    store_reg[wp_next] <= sample;
                end
            end
        end
    end

    // ---------------------------------------------------------------- cell chain
    for (genvar c = 0; c < MAX_WINDOW; c++)
    begin : g_cell
        cell_link_t left_l;
        cell_link_t right_l;

        if (c == 0)
        begin : g_head
            assign left_l = '{vld: 1'b0, gt: 1'b0, value: '0};
        end
        else
        begin : g_mid
            assign left_l = links[c-1];
        end

        if (c == MAX_WINDOW - 1)
        begin : g_tail
            assign right_l = '{vld: 1'b0, gt: 1'b1, value: '0};
        end
        else
        begin : g_body
            assign right_l = links[c+1];
        end

        tmwf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .left_link  (left_l),
            .right_link (right_l),
            .link       (links[c])
        );
    end

    // ---------------------------------------------------------------- divide
    tmwf_divider #(
        .DVD_W (SUM_W),
        .DVS_W (WIN_W),
        .QUO_W (SAMPLE_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_next),
        .divisor  (trim_hi - trim_lo),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            smoothed_valid_reg <= 1'b1;
        end
        else if (!smoothed_stall)
        begin
            smoothed_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            smoothed_reg <= div_quotient;
        end
    end

    assign smoothed_valid = smoothed_valid_reg;
    assign smoothed       = smoothed_reg;
    assign sample_stall   = (state_reg != ST_IDLE);

endmodule

// ===== src/tmwf_cell.sv =====
// one cell of the sorting chain: holds one window value, inserts and shifts with neighbors
module tmwf_cell
    import tmwf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_link_t left_link,
    input  cell_link_t right_link,
    output cell_link_t link
);

    logic    vld_reg;
    logic    vld_next;
    sample_t val_reg;
    sample_t val_next;
    logic    gt;

    // empty cells count as larger than anything
    assign gt = !vld_reg || (ctrl.data < val_reg);

    always_comb
    begin
        vld_next = vld_reg;
        val_next = val_reg;
        unique case (ctrl.op)
            CELL_CLEAR:
            begin
                vld_next = 1'b0;
            end
            CELL_INSERT:
            begin
                if (gt)
                begin
                    if (left_link.gt)
                    begin
                        vld_next = left_link.vld;
                        val_next = left_link.value;
                    end
                    else
                    begin
                        vld_next = 1'b1;
                        val_next = ctrl.data;
                    end
                end
            end
            CELL_SHIFT:
            begin
                vld_next = right_link.vld;
                val_next = right_link.value;
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link = '{vld: vld_reg, gt: gt, value: val_reg};

endmodule

// ===== src/tmwf_divider.sv =====
// serial restoring divider, signed dividend by unsigned divisor, truncates toward zero
module tmwf_divider
    import tmwf_pkg::*;
#(
    parameter int DVD_W = 21,
    parameter int DVS_W = 5,
    parameter int QUO_W = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic        [DVS_W-1:0] divisor,
    output logic                    done,
    output logic signed [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;

    logic [DVD_W-1:0] mag;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [DVD_W-1:0] q_signed;

    assign mag     = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DVD_W-1];
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= mag;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign q_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = q_signed[QUO_W-1:0];
    assign done     = done_reg;

endmodule

// ===== src/tmwf_checker.sv =====
// port-level checks for the trimmed mean window filter, bound to the top level
module tmwf_checker
    import tmwf_pkg::*;
#(
    parameter int MAX_WINDOW = 16
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_valid,
    input logic                       sample_stall,
    input logic                       smoothed_valid,
    input logic                       smoothed_stall,
    input logic signed [SAMPLE_W-1:0] smoothed,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic        [APB_AW-1:0]   paddr,
    input logic        [APB_DW-1:0]   prdata,
    input logic                       pready
);

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        smoothed_valid && smoothed_stall |=> smoothed_valid && $stable(smoothed))
        else $error("stalled result changed");

    // one sample at a time: busy right after a transfer
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("input not stalled after transfer");

    // a new result appears together with the input opening again
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(smoothed_valid) |-> !sample_stall)
        else $error("result shown while input still stalled");

    // the window size read back is always a legal size
    a_window_legal: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[APB_AW-1] == REG_WINDOW) && pready
            |-> (prdata >= APB_DW'(WIN_MIN)) && (prdata <= APB_DW'(MAX_WINDOW)))
        else $error("window size out of range");

    // every write access phase completes at once
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |-> pready)
        else $error("write not completed");

endmodule

bind trimmed_mean_window_filter_top tmwf_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_tmwf_checker (.*);

// ===== tb/trimmed_mean_window_filter_top_test.sv =====
// testbench for the trimmed mean window filter: window prediction, register writes and handshakes
`timescale 1ns / 1ps

module trimmed_mean_window_filter_top_test
    import tmwf_pkg::*;
;

    localparam int MAX_WIN      = 16;
    localparam int CLK_HALF_NS  = 10;
    localparam int RUN_LIMIT_NS = 15_000_000;
    localparam int MAX_PRINTS   = 40;
    localparam int GAP_MAX      = 6;
    localparam int SETTLE_CYC   = 8;
    localparam int TAIL_CYC     = 100;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 150;

    // register map: index in paddr[2], the second slot has no register behind it
    localparam logic [APB_AW-1:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_SPARE  = {~REG_WINDOW, 2'b00};

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       smoothed_valid;
    logic                       smoothed_stall;
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic        [APB_AW-1:0]   paddr;
    logic        [APB_DW-1:0]   pwdata;
    logic        [APB_DW-1:0]   prdata;
    logic                       pready;

    // predicted window state, updated on every accepted sample transfer
    sample_t win_slots [MAX_WIN];
    int      win_ptr;
    int      win_len;

    // smoothed values still owed by the block, oldest first
    sample_t pending_smoothed [$];

    int error_count;
    int sensor_level;

    // idling controls: quiet means no gaps on that side
    bit tx_quiet;
    bit rx_quiet;
    int rx_hold_cycles;

    trimmed_mean_window_filter_top #(
        .MAX_WINDOW (MAX_WIN)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .smoothed_valid (smoothed_valid),
        .smoothed_stall (smoothed_stall),
        .smoothed       (smoothed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[trimmed_mean_window_filter_top] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want_v);
        if (error_count < MAX_PRINTS)
        begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want_v, $realtime);
        end
        error_count++;
    endtask

    // window size after a register write: even rounds up, then clamp high, then low
    function automatic int window_after_write(input logic [CFG_W-1:0] v);
        int w;
        w = v;
        if (w % 2 == 0)
        begin
            w++;
        end
        if (w > MAX_WIN)
        begin
            w = MAX_WIN;
        end
        if (w < WIN_MIN)
        begin
            w = WIN_MIN;
        end
        return w;
    endfunction

    function automatic void clear_window();
        foreach (win_slots[k])
        begin
            win_slots[k] = '0;
        end
        win_ptr = 0;
    endfunction

    // store one sample in the ring and return the trimmed mean of the whole window
    function automatic sample_t push_and_average(input sample_t s);
        int ranked [MAX_WIN];
        int v;
        int j;
        int lo;
        int hi;
        int total;
        win_ptr = (win_ptr + 1) % win_len;
        win_slots[win_ptr] = s;
        // ascending insertion sort, unwritten slots take part as zeros
        for (int i = 0; i < win_len; i++)
        begin
            v = win_slots[i];
            j = i;
            while (j > 0 && ranked[j-1] > v)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        lo = (win_len * TRIM_LO_PCT) / PCT_SCALE;
        if (lo < 1)
        begin
            lo = 1;
        end
        hi = (win_len * TRIM_HI_PCT) / PCT_SCALE + 1;
        if (hi > win_len - 1)
        begin
            hi = win_len - 1;
        end
        if (hi <= lo)
        begin
            return '0;
        end
        total = 0;
        for (int i = lo; i < hi; i++)
        begin
            total += ranked[i];
        end
        // int division truncates toward zero
        return sample_t'(total / (hi - lo));
    endfunction

    // sensor-like values: a drifting level with noise, plus outliers, extremes and raw noise
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0: return sample_t'(16'sh7FFF);
                1: return sample_t'(16'sh8000);
                2: return '0;
                default: return sample_t'(-1);
            endcase
        end
        if (pick <= 3)
        begin
            return sample_t'($urandom());
        end
        sensor_level += $signed($urandom_range(0, 200)) - 100;
        if (sensor_level > 30000 || sensor_level < -30000)
        begin
            sensor_level = 0;
        end
        if (pick == 4)
        begin
            // spike far from the level
            return sample_t'(sensor_level + ($urandom_range(0, 1) ? 20000 : -20000));
        end
        return sample_t'(sensor_level + $signed($urandom_range(0, 64)) - 32);
    endfunction

    // one sample transfer; valid drops at the next falling edge so no stale offer is left
    task automatic send_sample(input sample_t s);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid = 1'b1;
        sample       = s;
        do
        begin
            @(posedge clk);
        end
        while (!(sample_valid && !sample_stall));
        pending_smoothed.push_back(push_and_average(s));
        @(negedge clk);
        sample_valid = 1'b0;
    endtask

    // lower valid and wait for every owed result, then let the block settle
    task automatic wait_until_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_smoothed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // setup then access phase; the register takes the value at the access edge
    task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (addr[2] == REG_WINDOW)
        begin
            win_len = window_after_write(data[CFG_W-1:0]);
            clear_window();
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_check_window();
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_WINDOW;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata[CFG_W-1:0] !== CFG_W'(win_len))
        begin
            report_mismatch("window_size readback", prdata[CFG_W-1:0], win_len);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // receiver: random stall before each transfer, plus an occasional long hold-off
    initial
    begin
        int wait_cyc;
        forever
        begin
            @(negedge clk);
            wait_cyc = rx_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (wait_cyc > 0)
            begin
                smoothed_stall = 1'b1;
                repeat (wait_cyc) @(negedge clk);
            end
            if (rx_hold_cycles > 0)
            begin
                smoothed_stall = 1'b1;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            smoothed_stall = 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!(smoothed_valid && !smoothed_stall));
        end
    end

    // result checker: every transfer out is matched against the oldest prediction
    initial
    begin
        sample_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && smoothed_valid && !smoothed_stall)
            begin
                if (pending_smoothed.size() == 0)
                begin
                    report_mismatch("smoothed with nothing pending", smoothed, 0);
                end
                else
                begin
                    want = pending_smoothed.pop_front();
                    if (smoothed !== want)
                    begin
                        report_mismatch("smoothed", smoothed, want);
                    end
                end
            end
        end
    end

    // extremes right after reset, window of three, store still partly zero
    task automatic test_reset_window();
        sample_t corner [6];
        corner = '{sample_t'(16'sh7FFF), sample_t'(16'sh8000), sample_t'(16'sh5555),
                   sample_t'(16'shAAAA), sample_t'(-1), sample_t'(1)};
        cfg_check_window();
        foreach (corner[k])
        begin
            send_sample(corner[k]);
        end
        wait_until_drained();
    endtask

    // rounding and clamping of written sizes, upper data bits ignored
    task automatic test_window_writes();
        logic [APB_DW-1:0] sizes [8];
        sizes = '{32'd0, 32'd1, 32'd2, 32'd4, 32'd15, 32'd16, 32'd31, 32'hFFFF_FFE4};
        foreach (sizes[k])
        begin
            cfg_write(ADDR_WINDOW, sizes[k]);
            cfg_check_window();
            send_sample(sample_t'(16'sh7FFF));
            send_sample(sample_t'(16'sh8000));
            wait_until_drained();
        end
    endtask

    // a write to the empty register slot changes nothing, store included
    task automatic test_spare_address();
        cfg_write(ADDR_WINDOW, 32'd7);
        send_sample(sample_t'(1234));
        wait_until_drained();
        cfg_write(ADDR_SPARE, 32'd12);
        cfg_check_window();
        send_sample(sample_t'(-4321));
        wait_until_drained();
    endtask

    // long random stream over several window sizes, extremes first
    task automatic test_random_stream();
        logic [CFG_W-1:0] wv;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: wv = 5'd0;
                1: wv = 5'd31;
                2: wv = 5'd16;
                3: wv = 5'd3;
                default: wv = CFG_W'($urandom_range(0, 31));
            endcase
            cfg_write(ADDR_WINDOW, {APB_DW'($urandom()) & ~APB_DW'(5'h1F)} | APB_DW'(wv));
            // alternate full-rate stretches with random idling on both sides
            tx_quiet = (ph % 3 == 1);
            rx_quiet = (ph % 3 == 2) || (ph % 4 == 1);
            repeat (PHASE_ITEMS) send_sample(random_sample());
            wait_until_drained();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // receiver holds off for a long stretch while samples keep coming, so the input stalls
    task automatic test_output_backpressure();
        cfg_write(ADDR_WINDOW, 32'd16);
        tx_quiet       = 1'b1;
        rx_hold_cycles = LONG_HOLD;
        repeat (40) send_sample(random_sample());
        tx_quiet = 1'b0;
        wait_until_drained();
    endtask

    // sender stops until every result is out, then carries on in the same window
    task automatic test_sender_pause();
        cfg_write(ADDR_WINDOW, 32'd9);
        repeat (20) send_sample(random_sample());
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending_smoothed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) send_sample(random_sample());
        wait_until_drained();
    endtask

    initial
    begin
        // all inputs known from time zero
        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        smoothed_stall = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        error_count    = 0;
        sensor_level   = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        rx_hold_cycles = 0;
        win_len        = WIN_RESET;
        clear_window();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_window();
        test_window_writes();
        test_spare_address();
        test_random_stream();
        test_output_backpressure();
        test_sender_pause();

        // everything accepted: wait out the tail, then a margin for late strays
        while (pending_smoothed.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYC) @(posedge clk);
        if (error_count == 0)
        begin
            $display("[trimmed_mean_window_filter_top] OK");
        end
        else
        begin
            $display("[trimmed_mean_window_filter_top] ERROR");
        end
        $finish;
    end

endmodule
